// ===== design/sspi_pkg.sv =====
package sspi_pkg;

	// Event codes carried on the input tuser
	typedef enum logic [2:0] {
		OP_GYRO_IRQ     = 3'd0,
		OP_ACCEL_IRQ    = 3'd1,
		OP_COMPLETE     = 3'd2,
		OP_CONSUME_GYRO = 3'd3,
		OP_CONSUME_ACC  = 3'd4,
		OP_CONSUME_TEMP = 3'd5
	} op_t;

	// Source codes for launch_target and in_flight
	localparam logic [1:0] SRC_NONE  = 2'd0;
	localparam logic [1:0] SRC_GYRO  = 2'd1;
	localparam logic [1:0] SRC_ACCEL = 2'd2;
	localparam logic [1:0] SRC_TEMP  = 2'd3;

	// Per-source flags
	typedef struct packed {
		logic fresh;
		logic fly;
		logic req;
	} src_flags_t;

	// One result item
	typedef struct packed {
		logic       fresh_data;
		logic [1:0] in_flight;
		logic       accel_select_level;
		logic       gyro_select_level;
		logic [1:0] launch_target;
	} result_t;

endpackage

// ===== design/sensor_spi_transfer_scheduler.sv =====
// Transfer scheduler for one shared SPI DMA link serving gyro, accel and
// temperature reads.
// Input stream: one event per transfer; s_axis_tuser holds the event code,
// s_axis_tdata[0] the DMA busy flag. Output stream: exactly one result per
// event, carrying the launch decision, both chip select levels, the source
// in flight and, for consume events, whether that source held fresh data.
// cfg_we/cfg_wdata write launch_enable; write it only while no event is
// pending.
// An accepted event is held in the input register and its result in the
// result register. Throughput: one event per cycle while the receiver does
// not stall; the flag update and priority pick sit between the input register
// and the result register.
// Reset clears all flags and launch_enable and drives both chip selects high
// (deselected); no result is pending after reset.
// When the receiver stalls, the result register holds its item, the input
// register holds the next event, and s_axis_tready drops once both are full.
module sensor_spi_transfer_scheduler (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [0] dma_busy, [7:1] zero
	input  logic [2:0] s_axis_tuser,   // [2:0] op
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata    // [1:0] launch_target, [2] gyro_select_level,
	                                   // [3] accel_select_level, [5:4] in_flight,
	                                   // [6] fresh_data, [7] zero
);
	import sspi_pkg::*;

	logic       launch_enable_q;
	logic       valid_s1;
	logic [2:0] op_s1;
	logic       busy_s1;
	logic       advance_s1;

	src_flags_t gyro_q, accel_q, temp_q;
	src_flags_t gyro_d, accel_d, temp_d;
	logic       gyro_sel_q, accel_sel_q;
	logic       gyro_sel_d, accel_sel_d;

	logic       out_valid_q;
	result_t    result_q;
	result_t    result_d;

	logic       try_launch;

	// Handshake: the input stage moves on when the result register is free
	assign advance_s1    = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance_s1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, result_q};

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			launch_enable_q <= 1'b0;
		end else if (cfg_we) begin
			launch_enable_q <= cfg_wdata;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			op_s1   <= s_axis_tuser;
			busy_s1 <= s_axis_tdata[0];
		end
	end

	// Event handling, launch pick and result
	always_comb begin
		gyro_d      = gyro_q;
		accel_d     = accel_q;
		temp_d      = temp_q;
		gyro_sel_d  = gyro_sel_q;
		accel_sel_d = accel_sel_q;
		try_launch  = 1'b0;
		result_d    = '0;

		case (op_s1)
			OP_GYRO_IRQ: begin
				gyro_d.req = 1'b1;
				try_launch = launch_enable_q;
			end
			OP_ACCEL_IRQ: begin
				accel_d.req = 1'b1;
				temp_d.req  = 1'b1;
				try_launch  = launch_enable_q;
			end
			OP_COMPLETE: begin
				if (gyro_q.fly) begin
					gyro_d.fly   = 1'b0;
					gyro_d.fresh = 1'b1;
					gyro_sel_d   = 1'b1;
				end
				if (accel_q.fly) begin
					accel_d.fly   = 1'b0;
					accel_d.fresh = 1'b1;
					accel_sel_d   = 1'b1;
				end
				if (temp_q.fly) begin
					temp_d.fly   = 1'b0;
					temp_d.fresh = 1'b1;
					accel_sel_d  = 1'b1;
				end
				try_launch = 1'b1;
			end
			OP_CONSUME_GYRO: begin
				result_d.fresh_data = gyro_q.fresh;
				gyro_d.fresh        = 1'b0;
			end
			OP_CONSUME_ACC: begin
				result_d.fresh_data = accel_q.fresh;
				accel_d.fresh       = 1'b0;
			end
			OP_CONSUME_TEMP: begin
				result_d.fresh_data = temp_q.fresh;
				temp_d.fresh        = 1'b0;
			end
			default: begin
			end
		endcase

		// Start the highest-priority request when the link is free
		if (try_launch && !busy_s1 && !(gyro_d.fly || accel_d.fly || temp_d.fly)) begin
			if (gyro_d.req) begin
				gyro_d.req             = 1'b0;
				gyro_d.fly             = 1'b1;
				gyro_sel_d             = 1'b0;
				result_d.launch_target = SRC_GYRO;
			end else if (accel_d.req) begin
				accel_d.req            = 1'b0;
				accel_d.fly            = 1'b1;
				accel_sel_d            = 1'b0;
				result_d.launch_target = SRC_ACCEL;
			end else if (temp_d.req) begin
				temp_d.req             = 1'b0;
				temp_d.fly             = 1'b1;
				accel_sel_d            = 1'b0;
				result_d.launch_target = SRC_TEMP;
			end
		end

		if (gyro_d.fly) begin
			result_d.in_flight = SRC_GYRO;
		end else if (accel_d.fly) begin
			result_d.in_flight = SRC_ACCEL;
		end else if (temp_d.fly) begin
			result_d.in_flight = SRC_TEMP;
		end else begin
			result_d.in_flight = SRC_NONE;
		end
		result_d.gyro_select_level  = gyro_sel_d;
		result_d.accel_select_level = accel_sel_d;
	end

	// Scheduler state, updated as each event moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gyro_q      <= '0;
			accel_q     <= '0;
			temp_q      <= '0;
			gyro_sel_q  <= 1'b1;
			accel_sel_q <= 1'b1;
		end else if (advance_s1) begin
			gyro_q      <= gyro_d;
			accel_q     <= accel_d;
			temp_q      <= temp_d;
			gyro_sel_q  <= gyro_sel_d;
			accel_sel_q <= accel_sel_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1) begin
			result_q <= result_d;
		end
	end

	// At most one source is ever in flight
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({gyro_q.fly, accel_q.fly, temp_q.fly}))
		else $error("more than one source in flight");

	// A source in flight keeps its chip select low
	a_gyro_select: assert property (@(posedge clk) disable iff (!arst_n)
		gyro_q.fly |-> !gyro_sel_q)
		else $error("gyro in flight with chip select high");

	a_accel_select: assert property (@(posedge clk) disable iff (!arst_n)
		(accel_q.fly || temp_q.fly) |-> !accel_sel_q)
		else $error("accel or temperature in flight with chip select high");

	// A reported launch names the source now in flight
	a_launch_matches: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && result_q.launch_target != SRC_NONE)
			|-> result_q.in_flight == result_q.launch_target)
		else $error("launch target differs from source in flight");

	// State does not move while the result register is stalled
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_axis_tready) |=> $stable({gyro_q, accel_q, temp_q}))
		else $error("flags changed during output stall");

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import sspi_pkg::*;

	// One scheduler event as it travels on the input stream
	typedef struct packed {
		logic [2:0] op;
		logic       busy;
	} sensor_event_t;

	// Event codes the block must ignore
	localparam logic [2:0] OP_UNUSED_LO = 3'd6;
	localparam logic [2:0] OP_UNUSED_HI = 3'd7;

	localparam int RESET_CYCLES  = 12;
	localparam int SETTLE_CYCLES = 4;
	localparam int QUIET_LIMIT   = 2000;
	localparam int PHASE_EVENTS  = 150;

	logic       clk           = 1'b0;
	logic       arst_n        = 1'b0;
	logic       cfg_we        = 1'b0;
	logic       cfg_wdata     = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata  = 8'd0;   // [0] dma_busy
	logic [2:0] s_axis_tuser  = 3'd0;   // [2:0] op
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;           // [1:0] launch, [2] gyro cs, [3] accel cs,
	                                    // [5:4] in flight, [6] fresh

	sensor_event_t event_queue[$];
	result_t       expected_results[$];
	sensor_event_t next_event;
	result_t       want_result;
	result_t       seen_result;
	bit            event_on_bus   = 1'b0;
	int            send_idle_pct  = 0;
	int            recv_stall_pct = 0;
	int            mismatches     = 0;
	int            quiet_cycles   = 0;

	// Scheduler state as predicted by the testbench
	src_flags_t gyro_st   = '0;
	src_flags_t accel_st  = '0;
	src_flags_t temp_st   = '0;
	logic       gyro_cs   = 1'b1;
	logic       accel_cs  = 1'b1;
	logic       launch_en = 1'b0;

	sensor_spi_transfer_scheduler uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Start the highest-priority requested source if the link is free
	function automatic logic [1:0] pick_launch(input logic busy);
		if (busy || gyro_st.fly || accel_st.fly || temp_st.fly)
			return SRC_NONE;
		if (gyro_st.req) begin
			gyro_st.req = 1'b0;
			gyro_st.fly = 1'b1;
			gyro_cs     = 1'b0;
			return SRC_GYRO;
		end
		if (accel_st.req) begin
			accel_st.req = 1'b0;
			accel_st.fly = 1'b1;
			accel_cs     = 1'b0;
			return SRC_ACCEL;
		end
		if (temp_st.req) begin
			// temperature shares the accel chip select
			temp_st.req = 1'b0;
			temp_st.fly = 1'b1;
			accel_cs    = 1'b0;
			return SRC_TEMP;
		end
		return SRC_NONE;
	endfunction

	// Apply one event to the predicted state and return its result
	function automatic result_t predict_event(input logic [2:0] op, input logic busy);
		result_t r;
		r = '0;
		case (op)
			OP_GYRO_IRQ: begin
				gyro_st.req = 1'b1;
				if (launch_en)
					r.launch_target = pick_launch(busy);
			end
			OP_ACCEL_IRQ: begin
				accel_st.req = 1'b1;
				temp_st.req  = 1'b1;
				if (launch_en)
					r.launch_target = pick_launch(busy);
			end
			OP_COMPLETE: begin
				if (gyro_st.fly) begin
					gyro_st.fly   = 1'b0;
					gyro_st.fresh = 1'b1;
					gyro_cs       = 1'b1;
				end
				if (accel_st.fly) begin
					accel_st.fly   = 1'b0;
					accel_st.fresh = 1'b1;
					accel_cs       = 1'b1;
				end
				if (temp_st.fly) begin
					temp_st.fly   = 1'b0;
					temp_st.fresh = 1'b1;
					accel_cs      = 1'b1;
				end
				r.launch_target = pick_launch(busy);
			end
			OP_CONSUME_GYRO: begin
				r.fresh_data  = gyro_st.fresh;
				gyro_st.fresh = 1'b0;
			end
			OP_CONSUME_ACC: begin
				r.fresh_data   = accel_st.fresh;
				accel_st.fresh = 1'b0;
			end
			OP_CONSUME_TEMP: begin
				r.fresh_data  = temp_st.fresh;
				temp_st.fresh = 1'b0;
			end
			default: begin
			end
		endcase
		r.gyro_select_level  = gyro_cs;
		r.accel_select_level = accel_cs;
		if (gyro_st.fly)
			r.in_flight = SRC_GYRO;
		else if (accel_st.fly)
			r.in_flight = SRC_ACCEL;
		else if (temp_st.fly)
			r.in_flight = SRC_TEMP;
		else
			r.in_flight = SRC_NONE;
		return r;
	endfunction

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// Random event: mostly irqs, completes and consumes, a few unused codes
	function automatic sensor_event_t random_event();
		sensor_event_t ev;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 25)
			ev.op = OP_GYRO_IRQ;
		else if (pick < 45)
			ev.op = OP_ACCEL_IRQ;
		else if (pick < 70)
			ev.op = OP_COMPLETE;
		else if (pick < 95)
			ev.op = 3'(OP_CONSUME_GYRO + $urandom_range(0, 2));
		else
			ev.op = ($urandom_range(0, 1) != 0) ? OP_UNUSED_HI : OP_UNUSED_LO;
		ev.busy = ($urandom_range(0, 99) < 20);
		return ev;
	endfunction

	function automatic void add_event(input logic [2:0] op, input logic busy);
		sensor_event_t ev;
		ev.op   = op;
		ev.busy = busy;
		event_queue.push_back(ev);
	endfunction

	function automatic void queue_random(input int count);
		for (int i = 0; i < count; i++)
			event_queue.push_back(random_event());
	endfunction

	// Hold until every queued event has transferred and every result has come back
	task automatic wait_quiet();
		while (event_queue.size() > 0 || event_on_bus || expected_results.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_launch_enable(input logic value);
		wait_quiet();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		launch_en  = value;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Drive events from the queue; predict each one as it transfers
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_results.push_back(predict_event(s_axis_tuser, s_axis_tdata[0]));
				event_on_bus = 1'b0;
			end
			if (!event_on_bus) begin
				if (event_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					next_event     = event_queue.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tuser  <= next_event.op;
					s_axis_tdata  <= {7'd0, next_event.busy};
					event_on_bus   = 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Compare each result transfer with the oldest prediction; stall at random
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				seen_result = result_t'(m_axis_tdata[6:0]);
				if (expected_results.size() == 0) begin
					$display("%0t ns: result with none expected, expected none, actual %h",
						$time, m_axis_tdata);
					mismatches++;
				end else begin
					want_result = expected_results.pop_front();
					check_field("launch_target", want_result.launch_target,
						seen_result.launch_target);
					check_field("gyro_select_level", want_result.gyro_select_level,
						seen_result.gyro_select_level);
					check_field("accel_select_level", want_result.accel_select_level,
						seen_result.accel_select_level);
					check_field("in_flight", want_result.in_flight, seen_result.in_flight);
					check_field("fresh_data", want_result.fresh_data, seen_result.fresh_data);
				end
			end
			m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// End the run if nothing transfers for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t ns: no transfer for %0d cycles", $time, QUIET_LIMIT);
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Launch disabled: interrupts only record requests
		add_event(OP_GYRO_IRQ, 1'b0);
		add_event(OP_ACCEL_IRQ, 1'b1);
		add_event(OP_GYRO_IRQ, 1'b0);        // repeated request
		add_event(OP_UNUSED_LO, 1'b0);
		add_event(OP_UNUSED_HI, 1'b1);
		add_event(OP_COMPLETE, 1'b1);        // nothing in flight, link busy
		add_event(OP_COMPLETE, 1'b0);        // nothing in flight, launches gyro
		add_event(OP_CONSUME_GYRO, 1'b0);
		add_event(OP_ACCEL_IRQ, 1'b0);       // gyro still in flight
		add_event(OP_COMPLETE, 1'b0);        // gyro fresh, accel launched
		add_event(OP_CONSUME_GYRO, 1'b1);
		add_event(OP_CONSUME_GYRO, 1'b0);

		// Launch enabled: interrupts start transfers when the link is free
		set_launch_enable(1'b1);
		add_event(OP_COMPLETE, 1'b0);        // accel fresh, temperature launched
		add_event(OP_GYRO_IRQ, 1'b0);        // temperature in flight
		add_event(OP_COMPLETE, 1'b1);        // temperature fresh, link busy
		add_event(OP_CONSUME_ACC, 1'b0);
		add_event(OP_CONSUME_TEMP, 1'b1);
		add_event(OP_CONSUME_TEMP, 1'b0);
		add_event(OP_GYRO_IRQ, 1'b1);        // link busy
		add_event(OP_GYRO_IRQ, 1'b0);
		add_event(OP_COMPLETE, 1'b0);
		add_event(OP_ACCEL_IRQ, 1'b0);
		add_event(OP_COMPLETE, 1'b0);
		add_event(OP_COMPLETE, 1'b0);
		add_event(OP_CONSUME_ACC, 1'b1);
		add_event(OP_UNUSED_HI, 1'b0);
		add_event(OP_UNUSED_LO, 1'b1);

		// Random traffic, no idling
		wait_quiet();
		queue_random(PHASE_EVENTS);

		// Launch disabled, sender mostly idle
		set_launch_enable(1'b0);
		send_idle_pct = 79;
		queue_random(PHASE_EVENTS);

		// Launch enabled, receiver mostly stalled, sender paused halfway
		set_launch_enable(1'b1);
		send_idle_pct  = 0;
		recv_stall_pct = 79;
		queue_random(PHASE_EVENTS / 2);
		wait_quiet();
		queue_random(PHASE_EVENTS / 2);

		// Both sides idle part of the time
		wait_quiet();
		send_idle_pct  = 38;
		recv_stall_pct = 38;
		queue_random(PHASE_EVENTS);

		wait_quiet();
		repeat (2 * SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/sspi_pkg.sv
design/sensor_spi_transfer_scheduler.sv
verif/tb_top.sv
